[rtl/ripple_peak_to_peak_meter_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef RIPPLE_PEAK_TO_PEAK_METER_UNIT_MACROS_SVH
`define RIPPLE_PEAK_TO_PEAK_METER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppm_pkg.sv]
package ppm_pkg;

  localparam int OUT_BITS  = 16;
  localparam int WIN_BITS  = 16;
  localparam int SKIP_BITS = 4;
  localparam int IDX_BITS  = 8;
  localparam int DATA_BITS = 16;

  localparam logic [WIN_BITS-1:0]  WINDOW_LEN_RESET = 16'd500;
  localparam logic [SKIP_BITS-1:0] SKIP_COUNT_RESET = 4'd3;

  localparam logic [IDX_BITS-1:0] REG_WINDOW_LEN = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_SKIP_COUNT = 8'd1;

  localparam logic CH_VOLT = 1'b0;
  localparam logic CH_CURR = 1'b1;

  typedef struct packed {
    logic [WIN_BITS-1:0]  window_len;
    logic [SKIP_BITS-1:0] skip_count;
  } cfg_t;

  typedef struct packed {
    logic                channel;
    logic [OUT_BITS-1:0] max_value;
    logic [OUT_BITS-1:0] min_value;
    logic [OUT_BITS-1:0] peak_to_peak;
  } result_t;

endpackage

[rtl/ripple_peak_to_peak_meter_unit.sv]
// Channel  Handshake               Payload
// in       in_valid / in_stall     volt_sample, curr_sample
// out      out_valid / out_stall   channel, max_value, min_value, peak_to_peak
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One input item per cycle while in_stall is low; a window result appears in
// the cycle after the item that closes the window. Besides the compare against
// the running max and min, a counter and a subtractor sit between the registers.
// Reset (rst, synchronous) starts in the voltage phase with an empty window.
// in_stall rises only when the output register is full and stalled and the
// next item would close a window; cfg_ready is always high.
module ripple_peak_to_peak_meter_unit import ppm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] volt_sample,
  input  logic [SAMPLE_BITS-1:0] curr_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   channel,
  output logic [OUT_BITS-1:0]    max_value,
  output logic [OUT_BITS-1:0]    min_value,
  output logic [OUT_BITS-1:0]    peak_to_peak,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_BITS-1:0]    cfg_index,
  input  logic [DATA_BITS-1:0]   cfg_data
);

  cfg_t    cfg;
  logic    accept;
  logic    done;
  logic    fire;
  result_t win_result;
  result_t out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_len <= WINDOW_LEN_RESET;
      cfg.skip_count <= SKIP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_LEN: cfg.window_len <= cfg_data[WIN_BITS-1:0];
        REG_SKIP_COUNT: cfg.skip_count <= cfg_data[SKIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Items that only extend the window never wait on the output side.
  assign in_stall = out_valid && out_stall && done;
  assign accept   = in_valid && !in_stall;

  ppm_window #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .volt_sample(volt_sample),
    .curr_sample(curr_sample),
    .done       (done),
    .fire       (fire),
    .result     (win_result)
  );

  ppm_result_reg u_result_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .load_data(win_result),
    .stall    (out_stall),
    .valid    (out_valid),
    .data     (out_data)
  );

  assign channel      = out_data.channel;
  assign max_value    = out_data.max_value;
  assign min_value    = out_data.min_value;
  assign peak_to_peak = out_data.peak_to_peak;

endmodule

[rtl/ppm_window.sv]
module ppm_window import ppm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] volt_sample,
  input  logic [SAMPLE_BITS-1:0] curr_sample,
  output logic                   done,
  output logic                   fire,
  output result_t                result
);

  localparam int W = (SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS : OUT_BITS;

  logic                   phase;
  logic [WIN_BITS-1:0]    sample_count;
  logic [SAMPLE_BITS-1:0] running_max;
  logic [SAMPLE_BITS-1:0] running_min;

  logic [SAMPLE_BITS-1:0] s;
  logic                   counted;
  logic [SAMPLE_BITS-1:0] diff;
  logic [W-1:0]           max_w;
  logic [W-1:0]           min_w;
  logic [W-1:0]           diff_w;

  assign s       = phase ? curr_sample : volt_sample;
  assign done    = (sample_count >= cfg.window_len);
  assign counted = (sample_count >= WIN_BITS'(cfg.skip_count));
  assign fire    = accept && done;

  // An empty window leaves max below min; the difference then reads zero.
  assign diff   = (running_max >= running_min) ? (running_max - running_min) : '0;
  assign max_w  = W'(running_max);
  assign min_w  = W'(running_min);
  assign diff_w = W'(diff);

  assign result.channel      = phase;
  assign result.max_value    = max_w[OUT_BITS-1:0];
  assign result.min_value    = min_w[OUT_BITS-1:0];
  assign result.peak_to_peak = diff_w[OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= CH_VOLT;
      sample_count <= '0;
      running_max  <= '0;
      running_min  <= '1;
    end else if (accept) begin
      if (done) begin
        phase        <= ~phase;
        sample_count <= '0;
        running_max  <= '0;
        running_min  <= '1;
      end else begin
        if (counted) begin
          if (s > running_max) running_max <= s;
          if (s < running_min) running_min <= s;
        end
        sample_count <= sample_count + WIN_BITS'(1);
      end
    end
  end

endmodule

[rtl/ppm_result_reg.sv]
module ppm_result_reg import ppm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  input  logic    stall,
  output logic    valid,
  output result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

[rtl/ppm_checker.sv]
`include "ripple_peak_to_peak_meter_unit_macros.svh"

module ppm_checker import ppm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                channel,
  input logic [OUT_BITS-1:0] max_value,
  input logic [OUT_BITS-1:0] min_value,
  input logic [OUT_BITS-1:0] peak_to_peak
);

  logic seen;
  logic last_channel;
  logic narrow;

  assign narrow = (SAMPLE_BITS <= OUT_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && !out_stall) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_channel <= channel;
    end
  end

  `PPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(channel) && $stable(max_value) && $stable(min_value) && $stable(peak_to_peak), "stalled result changed")
  `PPM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")
  `PPM_ASSERT_NOW(a_alternate, out_valid && seen, channel != last_channel, "two results of the same channel in a row")
  `PPM_ASSERT_NOW(a_diff, out_valid && narrow && (max_value >= min_value), peak_to_peak == max_value - min_value, "peak_to_peak is not max minus min")

endmodule

bind ripple_peak_to_peak_meter_unit ppm_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_ppm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .channel     (channel),
  .max_value   (max_value),
  .min_value   (min_value),
  .peak_to_peak(peak_to_peak)
);
